/* rtl/core/mcc_pkg.sv */
// Shared types and constants for the Markov context counter.
// Holds the request and result payloads and the store operation word.
// No dependencies.
package mcc_pkg;

    localparam logic FUNC_READ = 1'b1;

    localparam logic [2:0] BASE_T = 3'd3;

    localparam int ORDER_W = 3;
    localparam int OUT_W = 32;

    localparam int RES_DEPTH = 8;
    localparam int RES_PTR_W = 3;
    localparam int RES_CNT_W = 4;

    typedef struct packed {
        logic        func;
        logic [2:0]  base_code;
        logic        end_of_sequence;
        logic [11:0] read_context;
    } in_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] context_count;
        logic [OUT_W-1:0] next_a_count;
        logic [OUT_W-1:0] next_c_count;
        logic [OUT_W-1:0] next_g_count;
        logic [OUT_W-1:0] next_t_count;
        logic [OUT_W-1:0] single_base_count;
    } out_item_t;

    typedef struct packed {
        logic       rd;
        logic       trans_en;
        logic       eos_en;
        logic [1:0] col;
    } store_op_t;

endpackage

/* rtl/core/mcc_count_store.sv */
// Count stores: transition rows and end-of-sequence context counts.
// Read-modify-write with forwarding of the last write and a clearing pass.
// Depends on mcc_pkg.
module mcc_count_store #(
    parameter int ADDR_W = 12,
    parameter int COUNT_BITS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    output logic                      busy,
    input  logic                      op_valid,
    input  mcc_pkg::store_op_t        op,
    input  logic [ADDR_W-1:0]         trans_addr,
    input  logic [ADDR_W-1:0]         eos_addr,
    output logic                      rd_valid,
    output logic [4*COUNT_BITS-1:0]   rd_row,
    output logic [COUNT_BITS-1:0]     rd_eos
);
    import mcc_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;
    localparam int ROW_W = 4 * COUNT_BITS;

    logic [ROW_W-1:0]      trans_mem [DEPTH];
    logic [COUNT_BITS-1:0] eos_mem [DEPTH];

    logic                  clr_busy_reg;
    logic [ADDR_W-1:0]     clr_addr_reg;

    logic                  s1_valid_reg;
    store_op_t             s1_op_reg;
    logic [ADDR_W-1:0]     s1_trans_addr_reg;
    logic [ADDR_W-1:0]     s1_eos_addr_reg;
    logic [ROW_W-1:0]      trans_rd_reg;
    logic [COUNT_BITS-1:0] eos_rd_reg;

    logic                  fw_t_valid_reg;
    logic [ADDR_W-1:0]     fw_t_addr_reg;
    logic [ROW_W-1:0]      fw_t_data_reg;
    logic                  fw_e_valid_reg;
    logic [ADDR_W-1:0]     fw_e_addr_reg;
    logic [COUNT_BITS-1:0] fw_e_data_reg;

    logic [ROW_W-1:0]      trans_row;
    logic [ROW_W-1:0]      trans_new;
    logic [COUNT_BITS-1:0] eos_row;
    logic [COUNT_BITS-1:0] eos_new;
    logic                  trans_wr_en;
    logic                  eos_wr_en;
    logic                  trans_we;
    logic                  eos_we;
    logic [ADDR_W-1:0]     trans_wa;
    logic [ADDR_W-1:0]     eos_wa;
    logic [ROW_W-1:0]      trans_wd;
    logic [COUNT_BITS-1:0] eos_wd;

    // After reset every row is written with zero, one row per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s1_op_reg      <= '0;
            fw_t_valid_reg <= 1'b0;
            fw_e_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= op_valid;
            s1_op_reg      <= op;
            fw_t_valid_reg <= trans_wr_en;
            fw_e_valid_reg <= eos_wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_trans_addr_reg <= trans_addr;
        s1_eos_addr_reg   <= eos_addr;
        fw_t_addr_reg     <= s1_trans_addr_reg;
        fw_t_data_reg     <= trans_new;
        fw_e_addr_reg     <= s1_eos_addr_reg;
        fw_e_data_reg     <= eos_new;
    end

    always_comb
    begin
        if (fw_t_valid_reg && (fw_t_addr_reg == s1_trans_addr_reg))
        begin
            trans_row = fw_t_data_reg;
        end
        else
        begin
            trans_row = trans_rd_reg;
        end
        if (fw_e_valid_reg && (fw_e_addr_reg == s1_eos_addr_reg))
        begin
            eos_row = fw_e_data_reg;
        end
        else
        begin
            eos_row = eos_rd_reg;
        end

        trans_new = trans_row;
        for (int i = 0; i < 4; i++)
        begin
            if ((s1_op_reg.col == 2'(i)) && !(&trans_row[i*COUNT_BITS +: COUNT_BITS]))
            begin
                trans_new[i*COUNT_BITS +: COUNT_BITS] =
                    trans_row[i*COUNT_BITS +: COUNT_BITS] + 1'b1;
            end
        end
        eos_new = (&eos_row) ? eos_row : eos_row + 1'b1;

        trans_wr_en = s1_valid_reg && s1_op_reg.trans_en;
        eos_wr_en   = s1_valid_reg && s1_op_reg.eos_en;

        trans_we = clr_busy_reg || trans_wr_en;
        eos_we   = clr_busy_reg || eos_wr_en;
        trans_wa = clr_busy_reg ? clr_addr_reg : s1_trans_addr_reg;
        eos_wa   = clr_busy_reg ? clr_addr_reg : s1_eos_addr_reg;
        trans_wd = clr_busy_reg ? '0 : trans_new;
        eos_wd   = clr_busy_reg ? '0 : eos_new;
    end

    always_ff @(posedge clk)
    begin
        if (trans_we)
        begin
            trans_mem[trans_wa] <= trans_wd;
        end
        if (op_valid)
        begin
            trans_rd_reg <= trans_mem[trans_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (eos_we)
        begin
            eos_mem[eos_wa] <= eos_wd;
        end
        if (op_valid)
        begin
            eos_rd_reg <= eos_mem[eos_addr];
        end
    end

    assign busy     = clr_busy_reg;
    assign rd_valid = s1_valid_reg && s1_op_reg.rd;
    assign rd_row   = trans_row;
    assign rd_eos   = eos_row;

endmodule

/* rtl/core/mcc_read_sum.sv */
// Read result pipeline: clips the counts and forms the context total
// from the four transition counts and the end-of-sequence count. Depends on mcc_pkg.
module mcc_read_sum #(
    parameter int COUNT_BITS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_valid,
    input  logic [4*COUNT_BITS-1:0]  rd_row,
    input  logic [COUNT_BITS-1:0]    rd_eos,
    input  logic [COUNT_BITS-1:0]    rd_base,
    output logic                     push,
    output mcc_pkg::out_item_t       push_data
);
    import mcc_pkg::*;

    localparam int SUM_W = COUNT_BITS + 3;
    localparam int LIM_BITS = (COUNT_BITS < OUT_W) ? COUNT_BITS : OUT_W;
    localparam logic [SUM_W-1:0] SUM_LIM = SUM_W'((64'd1 << LIM_BITS) - 64'd1);

    function automatic logic [OUT_W-1:0] clip_out(input logic [COUNT_BITS-1:0] v);
        return (64'(v) > 64'hFFFF_FFFF) ? '1 : OUT_W'(v);
    endfunction

    logic                  a_valid_reg;
    logic [COUNT_BITS:0]   a_pair0_reg;
    logic [COUNT_BITS:0]   a_pair1_reg;
    logic [COUNT_BITS-1:0] a_eos_reg;
    out_item_t             a_item_reg;

    logic                  b_valid_reg;
    logic [COUNT_BITS+1:0] b_sum_reg;
    logic [COUNT_BITS-1:0] b_eos_reg;
    out_item_t             b_item_reg;

    logic [SUM_W-1:0]      total;
    logic [SUM_W-1:0]      total_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= rd_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_pair0_reg <= (COUNT_BITS+1)'(rd_row[0 +: COUNT_BITS])
                     + (COUNT_BITS+1)'(rd_row[COUNT_BITS +: COUNT_BITS]);
        a_pair1_reg <= (COUNT_BITS+1)'(rd_row[2*COUNT_BITS +: COUNT_BITS])
                     + (COUNT_BITS+1)'(rd_row[3*COUNT_BITS +: COUNT_BITS]);
        a_eos_reg   <= rd_eos;
        a_item_reg.context_count     <= '0;
        a_item_reg.next_a_count      <= clip_out(rd_row[0 +: COUNT_BITS]);
        a_item_reg.next_c_count      <= clip_out(rd_row[COUNT_BITS +: COUNT_BITS]);
        a_item_reg.next_g_count      <= clip_out(rd_row[2*COUNT_BITS +: COUNT_BITS]);
        a_item_reg.next_t_count      <= clip_out(rd_row[3*COUNT_BITS +: COUNT_BITS]);
        a_item_reg.single_base_count <= clip_out(rd_base);

        b_sum_reg  <= (COUNT_BITS+2)'(a_pair0_reg) + (COUNT_BITS+2)'(a_pair1_reg);
        b_eos_reg  <= a_eos_reg;
        b_item_reg <= a_item_reg;
    end

    // The context count equals the transition counts plus the end-of-sequence
    // count, limited to the counter and output ranges.
    always_comb
    begin
        total     = SUM_W'(b_sum_reg) + SUM_W'(b_eos_reg);
        total_sat = (total > SUM_LIM) ? SUM_LIM : total;
        push_data = b_item_reg;
        push_data.context_count = OUT_W'(total_sat);
    end

    assign push = b_valid_reg;

endmodule

/* rtl/core/mcc_result_fifo.sv */
// Result queue in front of the output channel.
// Depends on mcc_pkg for the result type and depth.
module mcc_result_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mcc_pkg::out_item_t  push_data,
    output logic                out_valid,
    input  logic                out_stall,
    output mcc_pkg::out_item_t  out_data
);
    import mcc_pkg::*;

    out_item_t              q_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0]   wr_ptr_reg;
    logic [RES_PTR_W-1:0]   rd_ptr_reg;
    logic [RES_CNT_W-1:0]   count_reg;
    logic                   pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = q_mem[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* rtl/core/markov_context_counter_top.sv */
// Top level of the Markov context counter.
// Instantiates mcc_count_store, mcc_read_sum and mcc_result_fifo; depends on mcc_pkg.
//
// Requests arrive on in_valid/in_stall/in_data. A count request carries one base and
// an end-of-sequence flag and gives no result; a read request returns the counts
// of one context on out_valid/out_stall/out_data. The Markov order is written on
// cfg_valid/cfg_ready/cfg_data; the user must write it only while the block is idle,
// which the block does not enforce. cfg_ready is always high. One request is accepted
// per cycle while in_stall is low. Counts live in two memories with registered reads;
// each count request reads a row, increments it in the next cycle and writes it back,
// and a request that follows directly picks the new row up by forwarding. Results
// wait in an eight-entry queue; when the receiver stalls, the queue fills and
// in_stall rises once eight read results are outstanding. After reset all
// 4**MAX_ORDER store rows are cleared, one row per cycle, and in_stall stays high
// during that pass. The order resets to one.
module markov_context_counter_top #(
    parameter int MAX_ORDER = 6,
    parameter int COUNT_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  mcc_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output mcc_pkg::out_item_t            out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mcc_pkg::ORDER_W-1:0]   cfg_data
);
    import mcc_pkg::*;

    localparam int CTX_W = 2 * MAX_ORDER;
    localparam int RUN_W = $clog2(MAX_ORDER + 1);

    logic [ORDER_W-1:0]    order_reg;
    logic [CTX_W-1:0]      window_reg;
    logic [RUN_W-1:0]      run_reg;
    logic [COUNT_BITS-1:0] base_tot_reg [4];
    logic [RES_CNT_W-1:0]  outstanding_reg;
    logic [COUNT_BITS-1:0] base_s1_reg;

    logic                  accept;
    logic                  is_read;
    logic                  base_ok;
    logic [RUN_W-1:0]      eff_order;
    logic [CTX_W-1:0]      ctx_mask;
    logic [RUN_W-1:0]      run_inc;
    logic [RUN_W-1:0]      run_after;
    logic [CTX_W-1:0]      window_after;
    logic [CTX_W-1:0]      read_addr;
    logic [CTX_W-1:0]      trans_addr;
    logic [CTX_W-1:0]      eos_addr;
    store_op_t             op;
    logic                  store_busy;
    logic                  rd_valid;
    logic [4*COUNT_BITS-1:0] rd_row;
    logic [COUNT_BITS-1:0] rd_eos;
    logic                  push;
    out_item_t             push_data;
    logic                  res_take;

    assign cfg_ready = 1'b1;
    assign in_stall  = store_busy || (outstanding_reg == RES_CNT_W'(RES_DEPTH));
    assign accept    = in_valid && !in_stall;
    assign is_read   = (in_data.func == FUNC_READ);
    assign res_take  = out_valid && !out_stall;

    always_comb
    begin
        if (32'(order_reg) > 32'(MAX_ORDER))
        begin
            eff_order = RUN_W'(MAX_ORDER);
        end
        else
        begin
            eff_order = RUN_W'(order_reg);
        end
        ctx_mask = ~({CTX_W{1'b1}} << {eff_order, 1'b0});

        base_ok = (in_data.base_code <= BASE_T);
        run_inc = (32'(run_reg) >= 32'(MAX_ORDER)) ? run_reg : run_reg + 1'b1;
        run_after    = base_ok ? run_inc : '0;
        window_after = base_ok ? CTX_W'({window_reg, in_data.base_code[1:0]}) : window_reg;
        read_addr    = CTX_W'(in_data.read_context);

        op.rd       = is_read;
        op.trans_en = !is_read && base_ok && (run_reg >= eff_order);
        op.eos_en   = !is_read && in_data.end_of_sequence && (run_after >= eff_order);
        op.col      = in_data.base_code[1:0];

        trans_addr = is_read ? read_addr : (window_reg & ctx_mask);
        eos_addr   = is_read ? read_addr : (window_after & ctx_mask);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg       <= ORDER_W'(1);
            window_reg      <= '0;
            run_reg         <= '0;
            outstanding_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                base_tot_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                order_reg <= cfg_data;
            end
            if (accept && !is_read)
            begin
                window_reg <= in_data.end_of_sequence ? '0 : window_after;
                run_reg    <= in_data.end_of_sequence ? '0 : run_after;
                for (int i = 0; i < 4; i++)
                begin
                    if (base_ok && (in_data.base_code[1:0] == 2'(i))
                        && !(&base_tot_reg[i]))
                    begin
                        base_tot_reg[i] <= base_tot_reg[i] + 1'b1;
                    end
                end
            end
            case ({accept && is_read, res_take})
                2'b10:   outstanding_reg <= outstanding_reg + 1'b1;
                2'b01:   outstanding_reg <= outstanding_reg - 1'b1;
                default: outstanding_reg <= outstanding_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_read)
        begin
            base_s1_reg <= base_tot_reg[in_data.read_context[1:0]];
        end
    end

    mcc_count_store #(
        .ADDR_W     (CTX_W),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .busy       (store_busy),
        .op_valid   (accept),
        .op         (op),
        .trans_addr (trans_addr),
        .eos_addr   (eos_addr),
        .rd_valid   (rd_valid),
        .rd_row     (rd_row),
        .rd_eos     (rd_eos)
    );

    mcc_read_sum #(
        .COUNT_BITS (COUNT_BITS)
    ) u_sum (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_valid   (rd_valid),
        .rd_row     (rd_row),
        .rd_eos     (rd_eos),
        .rd_base    (base_s1_reg),
        .push       (push),
        .push_data  (push_data)
    );

    mcc_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule
